/* hdl/sha256_prng_byte_generator_macros.svh */
// Assertion macros shared by the generator RTL.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef SHA256_PRNG_BYTE_GENERATOR_MACROS_SVH
`define SHA256_PRNG_BYTE_GENERATOR_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define PBG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PBG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/s256pbg_pkg.sv */
// Shared types, constants and SHA-256 helper functions for the byte generator.
// Depends on nothing.
package s256pbg_pkg;

  localparam int STATE_BYTES = 32;
  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
  localparam logic [63:0] CHAIN_BITS = 64'd256;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_ROUND, ST_DONE, ST_UPDATE, ST_FIX, ST_EMIT
  } state_t;

  // Which message block the compression engine works on.
  typedef enum logic [2:0] {
    JOB_REFILL, JOB_FULL, JOB_PAD, JOB_TAIL, JOB_FINAL
  } job_t;

  // Layout of one message block.
  typedef struct packed {
    logic [4:0] nw;        // number of leading data words
    logic       pad_en;    // pad word follows the data words
    logic       len_en;    // bit length sits in the last two words
    logic       use_chain; // data words come from the chain state
  } blk_desc_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t byte_swap(input word_t x);
    byte_swap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic word_t h_init(input logic [2:0] i);
    case (i)
      3'd0: h_init = 32'h6a09e667;
      3'd1: h_init = 32'hbb67ae85;
      3'd2: h_init = 32'h3c6ef372;
      3'd3: h_init = 32'ha54ff53a;
      3'd4: h_init = 32'h510e527f;
      3'd5: h_init = 32'h9b05688c;
      3'd6: h_init = 32'h1f83d9ab;
      default: h_init = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t k_round(input logic [5:0] i);
    case (i)
      6'd0:  k_round = 32'h428a2f98; 6'd1:  k_round = 32'h71374491;
      6'd2:  k_round = 32'hb5c0fbcf; 6'd3:  k_round = 32'he9b5dba5;
      6'd4:  k_round = 32'h3956c25b; 6'd5:  k_round = 32'h59f111f1;
      6'd6:  k_round = 32'h923f82a4; 6'd7:  k_round = 32'hab1c5ed5;
      6'd8:  k_round = 32'hd807aa98; 6'd9:  k_round = 32'h12835b01;
      6'd10: k_round = 32'h243185be; 6'd11: k_round = 32'h550c7dc3;
      6'd12: k_round = 32'h72be5d74; 6'd13: k_round = 32'h80deb1fe;
      6'd14: k_round = 32'h9bdc06a7; 6'd15: k_round = 32'hc19bf174;
      6'd16: k_round = 32'he49b69c1; 6'd17: k_round = 32'hefbe4786;
      6'd18: k_round = 32'h0fc19dc6; 6'd19: k_round = 32'h240ca1cc;
      6'd20: k_round = 32'h2de92c6f; 6'd21: k_round = 32'h4a7484aa;
      6'd22: k_round = 32'h5cb0a9dc; 6'd23: k_round = 32'h76f988da;
      6'd24: k_round = 32'h983e5152; 6'd25: k_round = 32'ha831c66d;
      6'd26: k_round = 32'hb00327c8; 6'd27: k_round = 32'hbf597fc7;
      6'd28: k_round = 32'hc6e00bf3; 6'd29: k_round = 32'hd5a79147;
      6'd30: k_round = 32'h06ca6351; 6'd31: k_round = 32'h14292967;
      6'd32: k_round = 32'h27b70a85; 6'd33: k_round = 32'h2e1b2138;
      6'd34: k_round = 32'h4d2c6dfc; 6'd35: k_round = 32'h53380d13;
      6'd36: k_round = 32'h650a7354; 6'd37: k_round = 32'h766a0abb;
      6'd38: k_round = 32'h81c2c92e; 6'd39: k_round = 32'h92722c85;
      6'd40: k_round = 32'ha2bfe8a1; 6'd41: k_round = 32'ha81a664b;
      6'd42: k_round = 32'hc24b8b70; 6'd43: k_round = 32'hc76c51a3;
      6'd44: k_round = 32'hd192e819; 6'd45: k_round = 32'hd6990624;
      6'd46: k_round = 32'hf40e3585; 6'd47: k_round = 32'h106aa070;
      6'd48: k_round = 32'h19a4c116; 6'd49: k_round = 32'h1e376c08;
      6'd50: k_round = 32'h2748774c; 6'd51: k_round = 32'h34b0bcb5;
      6'd52: k_round = 32'h391c0cb3; 6'd53: k_round = 32'h4ed8aa4a;
      6'd54: k_round = 32'h5b9cca4f; 6'd55: k_round = 32'h682e6ff3;
      6'd56: k_round = 32'h748f82ee; 6'd57: k_round = 32'h78a5636f;
      6'd58: k_round = 32'h84c87814; 6'd59: k_round = 32'h8cc70208;
      6'd60: k_round = 32'h90befffa; 6'd61: k_round = 32'ha4506ceb;
      6'd62: k_round = 32'hbef9a3f7; 6'd63: k_round = 32'hc67178f2;
      default: k_round = 32'h0;
    endcase
  endfunction

endpackage

/* hdl/s256pbg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module s256pbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sha256_prng_byte_generator.sv */
// SHA-256 based pseudo-random byte generator, top level.
// Depends on s256pbg_pkg, s256pbg_ram and sha256_prng_byte_generator_macros.svh.
//
// Usage:
// - Input channel (in_valid/in_ready): in_opcode 0 streams a 32-bit seed word,
//   hashed as four little-endian bytes; in_seed_last ends the seed message.
//   in_opcode 1 requests one random byte.
// - Result channel (out_valid/out_ready): one out_random_byte per request, none
//   for seed words. A finished byte sits in an output register, so the block
//   takes the next item while it waits, as long as it is taken by then.
// - A request served from the buffer gives its byte in the cycle after the
//   transfer. When the 32-byte buffer is empty the block first runs one
//   SHA-256 compression (a setup step, 64 rounds and an add step) and a
//   byte-serial chain update with a fix step, then emits the first byte;
//   it takes no new item until then. The next 31 requests use the buffer.
// - A seed word that fills the 64-byte block held in the seed RAM starts one
//   compression, others none; the last word adds one or two compressions.
// - Reset (rst_n low, synchronous) zeroes chain state and buffer, marks the
//   buffer empty and restarts the seed hash. A stalled receiver holds
//   in_ready low only while a byte is still pending at the next transfer.
module sha256_prng_byte_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_seed_word,
  input  logic        in_seed_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_random_byte
);
  import s256pbg_pkg::*;
  `include "sha256_prng_byte_generator_macros.svh"

  state_t     state_r, state_nxt;
  job_t       job_r, job_nxt;
  logic [5:0] rnd_r;
  word_t      wk_r [8];
  word_t      win_r [16];
  word_t      seed_h_r [8];
  logic [63:0] len_r;
  logic       last_r;
  byte_t      chain_r [STATE_BYTES];
  byte_t      buf_r [STATE_BYTES];
  logic [5:0] rdpos_r;
  logic [4:0] upd_cnt_r;
  logic [1:0] carry_r;
  logic       changed_r;
  logic       out_valid_r;
  byte_t      out_byte_r;

  logic       in_fire;
  logic       ram_we;
  logic [3:0] ram_raddr;
  word_t      ram_rdata;
  blk_desc_t  desc;
  logic [63:0] bit_len;
  word_t      src_word;
  word_t      w_cur;
  word_t      t1, t2;
  word_t      base [8];
  word_t      digest [8];
  logic [9:0] upd_sum;
  byte_t      upd_byte;
  logic       emit_now;

  assign in_fire = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_random_byte = out_byte_r;

  // Seed block storage, written one byte-swapped word per seed transfer.
  s256pbg_ram #(.WIDTH(32), .DEPTH(16)) u_seed_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[5:2]),
    .wdata (byte_swap(in_seed_word)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Block layout for the current job.
  always_comb begin
    desc = '0;
    case (job_r)
      JOB_REFILL: desc = '{nw: 5'd8, pad_en: 1'b1, len_en: 1'b1, use_chain: 1'b1};
      JOB_FULL:   desc = '{nw: 5'd16, pad_en: 1'b0, len_en: 1'b0, use_chain: 1'b0};
      JOB_PAD:    desc = '{nw: {1'b0, len_r[5:2]}, pad_en: 1'b1, len_en: 1'b0,
                           use_chain: 1'b0};
      JOB_TAIL:   desc = '{nw: 5'd0, pad_en: 1'b0, len_en: 1'b1, use_chain: 1'b0};
      JOB_FINAL:  desc = '{nw: {1'b0, len_r[5:2]}, pad_en: 1'b1, len_en: 1'b1,
                           use_chain: 1'b0};
      default:    desc = '0;
    endcase
  end

  assign bit_len = desc.use_chain ? CHAIN_BITS : {len_r[60:0], 3'b000};

  // Message word for the first 16 rounds.
  always_comb begin
    if ({1'b0, rnd_r[3:0]} < desc.nw) begin
      if (desc.use_chain) begin
        src_word = {chain_r[{rnd_r[2:0], 2'd0}], chain_r[{rnd_r[2:0], 2'd1}],
                    chain_r[{rnd_r[2:0], 2'd2}], chain_r[{rnd_r[2:0], 2'd3}]};
      end else begin
        src_word = ram_rdata;
      end
    end else if (desc.pad_en && ({1'b0, rnd_r[3:0]} == desc.nw)) begin
      src_word = PAD_WORD;
    end else if (desc.len_en && (rnd_r[3:0] == 4'd14)) begin
      src_word = bit_len[63:32];
    end else if (desc.len_en && (rnd_r[3:0] == 4'd15)) begin
      src_word = bit_len[31:0];
    end else begin
      src_word = '0;
    end
  end

  // Message schedule and one compression round.
  always_comb begin
    if (rnd_r < 6'd16) begin
      w_cur = src_word;
    end else begin
      w_cur = win_r[0] + ssig0(win_r[1]) + win_r[9] + ssig1(win_r[14]);
    end
    t1 = wk_r[7] + bsig1(wk_r[4]) + ((wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]))
         + k_round(rnd_r) + w_cur;
    t2 = bsig0(wk_r[0]) + ((wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]));
  end

  // Chaining value that the compression starts from and adds back.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      base[i] = (job_r == JOB_REFILL) ? h_init(3'(i)) : seed_h_r[i];
      digest[i] = base[i] + wk_r[i];
    end
  end

  // Signed byte add of the chain update.
  assign upd_sum = {{2{chain_r[0][7]}}, chain_r[0]} + {{2{buf_r[0][7]}}, buf_r[0]}
                   + {{8{carry_r[1]}}, carry_r};
  assign upd_byte = upd_sum[7:0];

  // Next state and job.
  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_opcode) begin
            if (rdpos_r[5]) begin
              state_nxt = ST_SETUP;
              job_nxt = JOB_REFILL;
            end
          end else if (len_r[5:2] == 4'd15) begin
            state_nxt = ST_SETUP;
            job_nxt = JOB_FULL;
          end else if (in_seed_last) begin
            state_nxt = ST_SETUP;
            job_nxt = (len_r[5:2] >= 4'd13) ? JOB_PAD : JOB_FINAL;
          end
        end
      end
      ST_SETUP: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == 6'd63) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        case (job_r)
          JOB_REFILL: state_nxt = ST_UPDATE;
          JOB_FULL: begin
            if (last_r) begin
              state_nxt = ST_SETUP;
              job_nxt = JOB_FINAL;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          JOB_PAD: begin
            state_nxt = ST_SETUP;
            job_nxt = JOB_TAIL;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_UPDATE: begin
        if (upd_cnt_r == 5'd31) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory control.
  always_comb begin
    in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    ram_we = in_fire && !in_opcode;
    emit_now = (in_fire && in_opcode && !rdpos_r[5]) || (state_r == ST_EMIT);
    case (state_r)
      ST_ROUND: ram_raddr = rnd_r[3:0] + 4'd1;
      default:  ram_raddr = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r <= JOB_REFILL;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r <= job_nxt;
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Generator state and compression datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdpos_r <= 6'(STATE_BYTES);
      len_r <= '0;
      for (int i = 0; i < 8; i++) begin
        seed_h_r[i] <= h_init(3'(i));
      end
      for (int i = 0; i < STATE_BYTES; i++) begin
        chain_r[i] <= '0;
        buf_r[i] <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire && in_opcode && !rdpos_r[5]) begin
            out_byte_r <= buf_r[rdpos_r[4:0]];
            rdpos_r <= rdpos_r + 6'd1;
          end
          if (in_fire && !in_opcode) begin
            len_r <= len_r + 64'd4;
            last_r <= in_seed_last;
          end
        end
        ST_SETUP: begin
          for (int i = 0; i < 8; i++) begin
            wk_r[i] <= base[i];
          end
          rnd_r <= '0;
        end
        ST_ROUND: begin
          wk_r[0] <= t1 + t2;
          wk_r[1] <= wk_r[0];
          wk_r[2] <= wk_r[1];
          wk_r[3] <= wk_r[2];
          wk_r[4] <= wk_r[3] + t1;
          wk_r[5] <= wk_r[4];
          wk_r[6] <= wk_r[5];
          wk_r[7] <= wk_r[6];
          for (int i = 0; i < 15; i++) begin
            win_r[i] <= win_r[i + 1];
          end
          win_r[15] <= w_cur;
          rnd_r <= rnd_r + 6'd1;
        end
        ST_DONE: begin
          case (job_r)
            JOB_REFILL: begin
              for (int i = 0; i < 8; i++) begin
                for (int j = 0; j < 4; j++) begin
                  buf_r[4 * i + j] <= digest[i][31 - 8 * j -: 8];
                end
              end
              upd_cnt_r <= '0;
              carry_r <= 2'b01;
              changed_r <= 1'b0;
            end
            JOB_FULL, JOB_PAD: begin
              for (int i = 0; i < 8; i++) begin
                seed_h_r[i] <= digest[i];
              end
            end
            default: begin
              // Seeding done: digest becomes chain state and buffer.
              for (int i = 0; i < 8; i++) begin
                for (int j = 0; j < 4; j++) begin
                  chain_r[4 * i + j] <= digest[i][31 - 8 * j -: 8];
                  buf_r[4 * i + j] <= digest[i][31 - 8 * j -: 8];
                end
                seed_h_r[i] <= h_init(3'(i));
              end
              rdpos_r <= 6'(STATE_BYTES);
              len_r <= '0;
            end
          endcase
        end
        ST_UPDATE: begin
          // Byte 0 is processed, then both arrays rotate down by one byte.
          for (int i = 0; i < STATE_BYTES - 1; i++) begin
            chain_r[i] <= chain_r[i + 1];
            buf_r[i] <= buf_r[i + 1];
          end
          chain_r[STATE_BYTES - 1] <= upd_byte;
          buf_r[STATE_BYTES - 1] <= buf_r[0];
          carry_r <= upd_sum[9:8];
          if (upd_byte != chain_r[0]) begin
            changed_r <= 1'b1;
          end
          upd_cnt_r <= upd_cnt_r + 5'd1;
        end
        ST_FIX: begin
          if (!changed_r) begin
            chain_r[0] <= chain_r[0] + 8'd1;
          end
        end
        ST_EMIT: begin
          out_byte_r <= buf_r[0];
          rdpos_r <= 6'd1;
        end
        default: begin
        end
      endcase
    end
  end

  `PBG_ASSERT_IMPL(a_ram_write_idle, ram_we, state_r == ST_IDLE, "seed RAM written while busy")
  `PBG_ASSERT_ALWAYS(a_len_aligned, len_r[1:0] == 2'b00, "seed length not word aligned")
  `PBG_ASSERT_NEXT(a_emit_pos, state_r == ST_EMIT, out_valid_r && (rdpos_r == 6'd1), "refill emit lost")
  `PBG_ASSERT_NEXT(a_refill_start, in_fire && in_opcode && rdpos_r[5], (state_r == ST_SETUP) && (job_r == JOB_REFILL) && !out_valid_r, "empty buffer not refilled")

endmodule
